@@ rtl/core/ezca_pkg.sv @@
// Shared types, constants and helpers of the edge zone color averager.
package ezca_pkg;

    localparam int SCREEN_WIDTH      = 1920;
    localparam int SCREEN_HEIGHT     = 1080;
    localparam int MAX_LEDS_PER_EDGE = 16;
    localparam int NUM_EDGES         = 4;
    localparam int LEN_W             = 13;
    localparam int CNT_W             = 5;
    localparam int SLOT_W            = 6;
    localparam int NUM_SLOTS         = 64;
    localparam int AREA_W            = 21;
    localparam int SUM_W             = 32;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_AW           = 2;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    typedef enum logic [2:0] {
        REG_MARGIN_LEFT,
        REG_MARGIN_RIGHT,
        REG_MARGIN_TOP,
        REG_MARGIN_BOTTOM,
        REG_EDGE_THICKNESS,
        REG_LEDS_TOP_BOTTOM,
        REG_LEDS_LEFT_RIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PR_IDLE,
        PR_LOAD,
        PR_DIV,
        PR_TAB
    } prep_state_t;

    typedef enum logic [2:0] {
        BK_ACC,
        BK_RD,
        BK_LOAD,
        BK_SAT,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              fe;
    } pix_t;

    typedef struct packed {
        logic [7:0]                          thick;
        logic [NUM_EDGES-1:0][LEN_W-1:0]     zone_len;
        logic [NUM_EDGES-1:0][CNT_W-1:0]     count;
    } geom_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        clamp_count = (v > CNT_W'(MAX_LEDS_PER_EDGE)) ? CNT_W'(MAX_LEDS_PER_EDGE) : v;
    endfunction

endpackage

@@ rtl/core/ezca_fifo.sv @@
// Short queue of classified pixel words between the front and the back.
module ezca_fifo
    import ezca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pix_t push_data,
    output logic full,
    input  logic pop,
    output pix_t pop_data,
    output logic empty
);

    pix_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("Queue written while full.");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("Queue read while empty.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Queue fill count lost a word.");

endmodule

@@ rtl/core/ezca_front.sv @@
// Configuration registers, zone table builder and pixel classifier.
module ezca_front
    import ezca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    output logic        push,
    output pix_t        push_data,
    input  logic        fifo_full,
    output geom_t       geom
);

    logic [11:0] ml_reg, mr_reg, mt_reg, mb_reg;
    logic [7:0]  thick_reg;
    logic [9:0]  ltb_reg, llr_reg;

    prep_state_t prep_state_reg, prep_state_next;
    logic [1:0]       edge_reg;
    logic [3:0]       step_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [LEN_W-1:0] quo_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [LEN_W-1:0] st_run_reg;
    logic [LEN_W-1:0] zl_reg [NUM_EDGES];
    logic [LEN_W-1:0] st_tab_reg [NUM_EDGES][MAX_LEDS_PER_EDGE];
    logic [LEN_W-1:0] en_tab_reg [NUM_EDGES][MAX_LEDS_PER_EDGE];

    logic [CNT_W-1:0] n [NUM_EDGES];
    logic signed [15:0] cw_s, sh_s;
    logic [LEN_W-1:0] cw_len, sh_len, len_sel;
    logic [CNT_W-1:0] n_sel;
    logic [5:0]       trial;
    logic             trial_ge;
    logic [LEN_W-1:0] zl_cur;
    logic [CNT_W-1:0] r_cur;
    logic [5:0]       acc2;

    logic [11:0] x, y;
    logic signed [15:0] xs, ys, lft, rgt, top, bot, tt;
    logic in_rect, side_rows;
    logic [3:0] flag_in;

    logic        s1_valid_reg;
    logic [3:0]  s1_flag_reg;
    logic [11:0] s1_posx_reg, s1_posy_reg;
    logic [7:0]  s1_red_reg, s1_green_reg, s1_blue_reg;
    logic        s1_fe_reg;

    logic [3:0]       zone [NUM_EDGES];
    logic [NUM_EDGES-1:0] ehit;
    logic [6:0]       slot7;
    logic             any_hit;

    assign n[EDGE_TOP]    = clamp_count(ltb_reg[4:0]);
    assign n[EDGE_BOTTOM] = clamp_count(ltb_reg[9:5]);
    assign n[EDGE_RIGHT]  = clamp_count(llr_reg[4:0]);
    assign n[EDGE_LEFT]   = clamp_count(llr_reg[9:5]);

    assign tt   = $signed({8'd0, thick_reg});
    assign cw_s = $signed(16'(SCREEN_WIDTH)) - $signed({4'd0, mr_reg})
                  - $signed({4'd0, ml_reg});
    assign sh_s = $signed(16'(SCREEN_HEIGHT)) - $signed({4'd0, mb_reg})
                  - $signed({4'd0, mt_reg}) - (tt <<< 1);
    assign cw_len  = cw_s[15] ? '0 : cw_s[LEN_W-1:0];
    assign sh_len  = sh_s[15] ? '0 : sh_s[LEN_W-1:0];
    assign len_sel = edge_reg[0] ? sh_len : cw_len;
    assign n_sel   = n[edge_reg];

    assign trial    = {rem_reg, quo_reg[LEN_W-1]};
    assign trial_ge = (trial >= {1'b0, n_sel});
    assign zl_cur   = (n_sel == '0) ? '0 : quo_reg;
    assign r_cur    = (n_sel == '0) ? '0 : rem_reg;
    assign acc2     = {1'b0, acc_reg} + {1'b0, r_cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ml_reg    <= '0;
            mr_reg    <= '0;
            mt_reg    <= '0;
            mb_reg    <= '0;
            thick_reg <= 8'd16;
            ltb_reg   <= '0;
            llr_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MARGIN_LEFT:     ml_reg    <= cfg_wdata;
                REG_MARGIN_RIGHT:    mr_reg    <= cfg_wdata;
                REG_MARGIN_TOP:      mt_reg    <= cfg_wdata;
                REG_MARGIN_BOTTOM:   mb_reg    <= cfg_wdata;
                REG_EDGE_THICKNESS:  thick_reg <= cfg_wdata[7:0];
                REG_LEDS_TOP_BOTTOM: ltb_reg   <= cfg_wdata[9:0];
                REG_LEDS_LEFT_RIGHT: llr_reg   <= cfg_wdata[9:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        prep_state_next = prep_state_reg;
        unique case (prep_state_reg)
            PR_IDLE: prep_state_next = PR_IDLE;
            PR_LOAD: prep_state_next = PR_DIV;
            PR_DIV:  prep_state_next = (step_reg == 4'(LEN_W-1)) ? PR_TAB : PR_DIV;
            PR_TAB:
            begin
                if (step_reg == 4'(MAX_LEDS_PER_EDGE-1))
                begin
                    prep_state_next = (edge_reg == EDGE_LEFT) ? PR_IDLE : PR_LOAD;
                end
            end
            default: prep_state_next = PR_IDLE;
        endcase
        if (cfg_wr)
        begin
            prep_state_next = PR_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_state_reg <= PR_IDLE;
            edge_reg       <= EDGE_TOP;
            step_reg       <= '0;
            zl_reg         <= '{default: '0};
        end
        else
        begin
            prep_state_reg <= prep_state_next;
            if (cfg_wr)
            begin
                edge_reg <= EDGE_TOP;
            end
            else if (prep_state_reg == PR_TAB && step_reg == 4'(MAX_LEDS_PER_EDGE-1))
            begin
                edge_reg <= edge_reg + 1'b1;
            end
            if (prep_state_reg == PR_LOAD || cfg_wr)
            begin
                step_reg <= '0;
            end
            else if (prep_state_reg == PR_DIV)
            begin
                step_reg <= (step_reg == 4'(LEN_W-1)) ? '0 : step_reg + 1'b1;
            end
            else if (prep_state_reg == PR_TAB)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (prep_state_reg == PR_TAB && step_reg == '0)
            begin
                zl_reg[edge_reg] <= zl_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (prep_state_reg)
            PR_LOAD:
            begin
                quo_reg    <= len_sel;
                rem_reg    <= '0;
                acc_reg    <= '0;
                st_run_reg <= '0;
            end
            PR_DIV:
            begin
                rem_reg <= trial_ge ? CNT_W'(trial - {1'b0, n_sel}) : trial[CNT_W-1:0];
                quo_reg <= {quo_reg[LEN_W-2:0], trial_ge};
            end
            PR_TAB:
            begin
                st_tab_reg[edge_reg][step_reg] <= st_run_reg;
                en_tab_reg[edge_reg][step_reg] <= st_run_reg + zl_cur;
                if (acc2 >= {1'b0, n_sel})
                begin
                    st_run_reg <= st_run_reg + zl_cur + 1'b1;
                    acc_reg    <= CNT_W'(acc2 - {1'b0, n_sel});
                end
                else
                begin
                    st_run_reg <= st_run_reg + zl_cur;
                    acc_reg    <= acc2[CNT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign x   = s_tdata[11:0];
    assign y   = s_tdata[23:12];
    assign xs  = $signed({4'd0, x});
    assign ys  = $signed({4'd0, y});
    assign lft = $signed({4'd0, ml_reg});
    assign top = $signed({4'd0, mt_reg});
    assign rgt = $signed(16'(SCREEN_WIDTH)) - $signed({4'd0, mr_reg});
    assign bot = $signed(16'(SCREEN_HEIGHT)) - $signed({4'd0, mb_reg});

    assign in_rect   = (xs >= lft) && (xs < rgt) && (ys >= top) && (ys < bot);
    assign side_rows = (ys >= top + tt) && (ys < bot - tt);
    assign flag_in[EDGE_TOP]    = in_rect && (ys < top + tt);
    assign flag_in[EDGE_RIGHT]  = in_rect && side_rows && (xs >= rgt - tt);
    assign flag_in[EDGE_BOTTOM] = in_rect && (ys >= bot - tt);
    assign flag_in[EDGE_LEFT]   = in_rect && side_rows && (xs < lft + tt);

    assign s_tready = (prep_state_reg == PR_IDLE) && (!s1_valid_reg || !fifo_full);
    assign push     = s1_valid_reg && !fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
        else if (push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_flag_reg  <= flag_in;
            s1_posx_reg  <= 12'(xs - lft);
            s1_posy_reg  <= 12'(ys - top - tt);
            s1_red_reg   <= s_tdata[31:24];
            s1_green_reg <= s_tdata[39:32];
            s1_blue_reg  <= s_tdata[47:40];
            s1_fe_reg    <= s_tlast;
        end
    end

    always_comb
    begin
        logic [LEN_W-1:0] pos;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            pos     = e[0] ? {1'b0, s1_posy_reg} : {1'b0, s1_posx_reg};
            zone[e] = '0;
            ehit[e] = 1'b0;
            for (int i = 0; i < MAX_LEDS_PER_EDGE; i++)
            begin
                if ((CNT_W'(i) < n[e]) && (pos >= st_tab_reg[e][i])
                    && (pos < en_tab_reg[e][i]))
                begin
                    zone[e] = 4'(i);
                    ehit[e] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [6:0] nt7, nr7, nb7, nl7;
        nt7     = {2'd0, n[EDGE_TOP]};
        nr7     = {2'd0, n[EDGE_RIGHT]};
        nb7     = {2'd0, n[EDGE_BOTTOM]};
        nl7     = {2'd0, n[EDGE_LEFT]};
        any_hit = 1'b1;
        slot7   = '0;
        if (s1_flag_reg[EDGE_TOP] && ehit[EDGE_TOP])
        begin
            slot7 = {3'd0, zone[EDGE_TOP]};
        end
        else if (s1_flag_reg[EDGE_RIGHT] && ehit[EDGE_RIGHT])
        begin
            slot7 = nt7 + {3'd0, zone[EDGE_RIGHT]};
        end
        else if (s1_flag_reg[EDGE_BOTTOM] && ehit[EDGE_BOTTOM])
        begin
            slot7 = nt7 + nr7 + nb7 - 7'd1 - {3'd0, zone[EDGE_BOTTOM]};
        end
        else if (s1_flag_reg[EDGE_LEFT] && ehit[EDGE_LEFT])
        begin
            slot7 = nt7 + nr7 + nb7 + nl7 - 7'd1 - {3'd0, zone[EDGE_LEFT]};
        end
        else
        begin
            any_hit = 1'b0;
        end
    end

    assign push_data.hit   = any_hit;
    assign push_data.slot  = slot7[SLOT_W-1:0];
    assign push_data.red   = s1_red_reg;
    assign push_data.green = s1_green_reg;
    assign push_data.blue  = s1_blue_reg;
    assign push_data.fe    = s1_fe_reg;

    assign geom.thick = thick_reg;
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            geom.zone_len[e] = zl_reg[e];
            geom.count[e]    = n[e];
        end
    end

endmodule

@@ rtl/core/ezca_back.sv @@
// Zone sum accumulator, mean divider and LED word output stage.
module ezca_back
    import ezca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    output logic        pop,
    input  pix_t        pop_data,
    input  logic        empty,
    input  geom_t       geom,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [3*SUM_W-1:0] sum_mem [NUM_SLOTS];
    logic [3*SUM_W-1:0] rd_reg;

    back_state_t state_reg, state_next;
    logic              init_reg;
    logic              a_valid_reg;
    pix_t              a_item_reg;
    logic              w_valid_reg;
    logic [SLOT_W-1:0] w_slot_reg;
    logic [3*SUM_W-1:0] w_data_reg;
    logic [SLOT_W-1:0] k_reg;
    logic [AREA_W-1:0] area_reg;
    logic [SUM_W-1:0]  rem_reg [3];
    logic [2:0]        sat_reg;
    logic [7:0]        q_reg [3];
    logic [2:0]        bit_reg;
    logic              zempty_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_idx_reg;
    logic [7:0]        out_mean_reg [3];
    logic              out_last_reg;
    logic              out_empty_reg;

    logic [3*SUM_W-1:0] base, acc_sum;
    logic              acc_we, mem_we;
    logic [SLOT_W-1:0] wa, ra;
    logic [3*SUM_W-1:0] wd;
    logic [6:0]        total, b1, b2, b3, k7;
    logic [LEN_W-1:0]  zl_sel;
    logic              out_load, k_last, emit;

    assign b1    = {2'd0, geom.count[EDGE_TOP]};
    assign b2    = b1 + {2'd0, geom.count[EDGE_RIGHT]};
    assign b3    = b2 + {2'd0, geom.count[EDGE_BOTTOM]};
    assign total = b3 + {2'd0, geom.count[EDGE_LEFT]};
    assign k7    = {1'b0, k_reg};
    assign k_last = (k_reg == SLOT_W'(NUM_SLOTS-1));
    assign emit   = (k7 < total) && !init_reg;

    always_comb
    begin
        if (k7 < b1)
        begin
            zl_sel = geom.zone_len[EDGE_TOP];
        end
        else if (k7 < b2)
        begin
            zl_sel = geom.zone_len[EDGE_RIGHT];
        end
        else if (k7 < b3)
        begin
            zl_sel = geom.zone_len[EDGE_BOTTOM];
        end
        else
        begin
            zl_sel = geom.zone_len[EDGE_LEFT];
        end
    end

    assign pop = (state_reg == BK_ACC) && !empty && !(a_valid_reg && a_item_reg.fe);

    assign base = (w_valid_reg && (w_slot_reg == a_item_reg.slot)) ? w_data_reg : rd_reg;

    always_comb
    begin
        logic [SUM_W:0] s;
        logic [7:0]     c;
        for (int l = 0; l < 3; l++)
        begin
            c = (l == 0) ? a_item_reg.red : ((l == 1) ? a_item_reg.green : a_item_reg.blue);
            s = {1'b0, base[l*SUM_W +: SUM_W]} + (SUM_W+1)'(c);
            acc_sum[l*SUM_W +: SUM_W] = s[SUM_W] ? '1 : s[SUM_W-1:0];
        end
    end

    assign acc_we = (state_reg == BK_ACC) && a_valid_reg && a_item_reg.hit;
    assign mem_we = acc_we || (state_reg == BK_RD);
    assign wa     = (state_reg == BK_RD) ? k_reg : a_item_reg.slot;
    assign wd     = (state_reg == BK_RD) ? '0 : acc_sum;
    assign ra     = (state_reg == BK_RD) ? k_reg : pop_data.slot;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[wa] <= wd;
        end
        rd_reg <= sum_mem[ra];
    end

    assign out_load = (state_reg == BK_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_ACC:  state_next = (a_valid_reg && a_item_reg.fe) ? BK_RD : BK_ACC;
            BK_RD:   state_next = BK_LOAD;
            BK_LOAD:
            begin
                if (emit)
                begin
                    state_next = BK_SAT;
                end
                else
                begin
                    state_next = k_last ? BK_ACC : BK_RD;
                end
            end
            BK_SAT:  state_next = (area_reg == '0) ? BK_OUT : BK_DIV;
            BK_DIV:  state_next = (bit_reg == '0) ? BK_OUT : BK_DIV;
            BK_OUT:
            begin
                if (out_load)
                begin
                    state_next = k_last ? BK_ACC : BK_RD;
                end
            end
            default: state_next = BK_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RD;
            init_reg      <= 1'b1;
            a_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_valid_reg <= pop;
            w_valid_reg <= acc_we;
            if (state_reg == BK_LOAD && k_last)
            begin
                init_reg <= 1'b0;
            end
            if (state_reg == BK_ACC)
            begin
                k_reg <= '0;
            end
            else if ((state_reg == BK_LOAD && !emit) || out_load)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_item_reg <= pop_data;
        end
        w_slot_reg <= a_item_reg.slot;
        w_data_reg <= acc_sum;
        unique case (state_reg)
            BK_LOAD:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[l] <= rd_reg[l*SUM_W +: SUM_W];
                end
                area_reg <= AREA_W'(zl_sel * geom.thick);
            end
            BK_SAT:
            begin
                zempty_reg <= (area_reg == '0);
                bit_reg    <= 3'd7;
                for (int l = 0; l < 3; l++)
                begin
                    q_reg[l]   <= '0;
                    sat_reg[l] <= (area_reg != '0)
                                  && (rem_reg[l] >= SUM_W'({area_reg, 8'd0}));
                end
            end
            BK_DIV:
            begin
                bit_reg <= bit_reg - 1'b1;
                for (int l = 0; l < 3; l++)
                begin
                    if (rem_reg[l] >= (SUM_W'(area_reg) << bit_reg))
                    begin
                        rem_reg[l]       <= rem_reg[l] - (SUM_W'(area_reg) << bit_reg);
                        q_reg[l][bit_reg] <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_idx_reg   <= k_reg;
            out_last_reg  <= ((k7 + 7'd1) == total);
            out_empty_reg <= zempty_reg;
            for (int l = 0; l < 3; l++)
            begin
                out_mean_reg[l] <= sat_reg[l] ? 8'hFF : q_reg[l];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_mean_reg[2], out_mean_reg[1], out_mean_reg[0], out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ACC && a_valid_reg && a_item_reg.fe) |=> (state_reg == BK_RD))
        else $error("Frame end did not start the LED burst.");
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg != BK_ACC) |-> !pop)
        else $error("Pixel word taken during the LED burst.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV && bit_reg == 3'd0) |=> (state_reg == BK_OUT))
        else $error("Mean division did not end after eight steps.");

endmodule

@@ rtl/core/edge_zone_color_averager_top.sv @@
// Top level of the edge zone color averager: front, queue and back.
// Pixel words are taken one per cycle unless a table rebuild or a full queue holds them. On a
// frame end word each LED steps through the read, load, saturate, divide and output states (an
// empty zone skips the divide), waiting on output stalls, and each slot beyond the last LED is
// read and cleared; the queue fills meanwhile. Each configuration write stalls input while the
// zone tables rebuild. After rst_n a sweep clears all 64 sums before any pixel word is summed.
module edge_zone_color_averager_top
    import ezca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_x, pixel_y, red_in, green_in, blue_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // led_index, red_mean, green_mean, blue_mean, zero fill
    output logic        m_tlast,
    output logic        m_tuser    // zone_empty
);

    logic  push, pop, fifo_full, fifo_empty;
    pix_t  push_data, pop_data;
    geom_t geom;

    ezca_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full),
        .geom      (geom)
    );

    ezca_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    ezca_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (fifo_empty),
        .geom     (geom),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
